// ===== sv/stream_replace_first_match_top_assert.svh =====
// Assertion macros for the stream_replace_first_match checker.
// Included by the checker file only; needs nothing else.
`ifndef STREAM_REPLACE_FIRST_MATCH_TOP_ASSERT_SVH
`define STREAM_REPLACE_FIRST_MATCH_TOP_ASSERT_SVH

// Property checked on every rising edge, off while reset is high.
`define SRFM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SRFM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/srfm_pkg.sv =====
// Shared types and constants for stream_replace_first_match.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package srfm_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;

  localparam int TEXT_W    = 64;
  localparam int LEN_W     = 4;
  localparam int REG_IDX_W = 2;

  // One item yields at most the larger text plus one passed byte.
  localparam int QDEPTH = ((PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX) + 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [7:0]        byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEARCH_PATTERN,
    REG_SEARCH_LENGTH,
    REG_REPLACEMENT_TEXT,
    REG_REPLACEMENT_LENGTH
  } reg_idx_t;

  typedef struct packed {
    logic                 write;
    logic [REG_IDX_W-1:0] index;
    logic [TEXT_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  replaced;
  } beat_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== sv/srfm_match.sv =====
// Match engine: configuration registers, held prefix bytes and the per-item
// decision that produces the beats of one item. Depends on srfm_pkg.
`timescale 1ns / 1ps

module srfm_match (
  input  logic                                     clk,
  input  logic                                     rst,
  input  srfm_pkg::cfg_wr_t                        cfg,
  input  logic                                     accept,
  input  srfm_pkg::byte_t                          in_byte,
  input  logic                                     in_last,
  output srfm_pkg::beat_t [srfm_pkg::QDEPTH-1:0]   emit,
  output srfm_pkg::qcnt_t                          emit_count
);
  import srfm_pkg::*;

  logic [TEXT_W-1:0] search_pattern;
  len_t              search_length;
  logic [TEXT_W-1:0] replacement_text;
  len_t              replacement_length;

  len_t  mp;
  logic  done;
  byte_t held [PATTERN_MAX];

  len_t  mp_next;
  logic  done_next;
  byte_t held_next [PATTERN_MAX];

  len_t  plen, rlen, mp_eff, cnt, start, win_len;
  byte_t win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok;
  logic  found, full, m_empty, m_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern     <= '0;
      search_length      <= '0;
      replacement_text   <= '0;
      replacement_length <= '0;
      mp                 <= '0;
      done               <= 1'b0;
    end else begin
      if (accept) begin
        done <= done_next;
      end
      // a pattern write drops the held prefix
      if (cfg.write && (cfg.index inside {REG_SEARCH_PATTERN, REG_SEARCH_LENGTH})) begin
        mp <= '0;
      end else if (accept) begin
        mp <= mp_next;
      end
      if (cfg.write) begin
        case (cfg.index)
          REG_SEARCH_PATTERN:     search_pattern     <= cfg.data;
          REG_SEARCH_LENGTH:      search_length      <= cfg.data[LEN_W-1:0];
          REG_REPLACEMENT_TEXT:   replacement_text   <= cfg.data;
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

  always_comb begin
    plen = (search_length > len_t'(PATTERN_MAX)) ? len_t'(PATTERN_MAX) : search_length;
    rlen = (replacement_length > len_t'(REPLACE_MAX)) ? len_t'(REPLACE_MAX)
                                                      : replacement_length;
    mp_eff = (mp >= plen) ? '0 : mp;
    cnt    = mp_eff + len_t'(1);
    // window = held prefix followed by the new byte
    for (int k = 0; k < PATTERN_MAX; k++) begin
      win[k] = (len_t'(k) < mp_eff) ? held[k] : in_byte;
    end
  end

  // ok[s]: window from offset s to its end is a pattern prefix
  always_comb begin
    for (int s = 0; s < PATTERN_MAX; s++) begin
      ok[s] = (len_t'(s) < cnt);
      for (int i = 0; i < PATTERN_MAX - s; i++) begin
        if ((len_t'(s + i) < cnt) && (win[s + i] != search_pattern[8*i +: 8])) begin
          ok[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    start = cnt;
    for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
      if (ok[s]) begin
        start = len_t'(s);
      end
    end
    found   = |ok;
    win_len = cnt - start;
    full    = found && (win_len >= plen);
    m_empty = !done && (plen == '0);
    m_full  = !done && (plen != '0) && full;
  end

  // surviving suffix moves to the front of the held row
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      held_next[i] = held[i];
      for (int s = 0; s < PATTERN_MAX - i; s++) begin
        if (start == len_t'(s)) begin
          held_next[i] = win[s + i];
        end
      end
    end
  end

  always_comb begin
    mp_next   = '0;
    done_next = done;
    if (done) begin
      emit_count = qcnt_t'(1);
    end else if (plen == '0) begin
      emit_count = qcnt_t'(rlen) + qcnt_t'(1);
      done_next  = 1'b1;
    end else if (full) begin
      emit_count = qcnt_t'(rlen);
      done_next  = 1'b1;
    end else begin
      // at line end the held suffix goes out right behind the released bytes
      emit_count = in_last ? qcnt_t'(cnt) : qcnt_t'(start);
      mp_next    = found ? win_len : '0;
    end
    if (in_last) begin
      mp_next   = '0;
      done_next = 1'b0;
    end
  end

  for (genvar k = 0; k < QDEPTH; k++) begin : g_slot
    byte_t rbyte, wbyte;
    logic  use_repl;
    if (k < REPLACE_MAX) begin : g_r
      assign rbyte = replacement_text[8*k +: 8];
    end else begin : g_nr
      assign rbyte = '0;
    end
    if (k < PATTERN_MAX) begin : g_w
      assign wbyte = win[k];
    end else begin : g_nw
      assign wbyte = in_byte;
    end
    assign use_repl = (m_empty || m_full) && (len_t'(k) < rlen);
    assign emit[k]  = '{
      data:     use_repl ? rbyte : ((done || m_empty) ? in_byte : wbyte),
      last:     in_last && (qcnt_t'(k + 1) == emit_count),
      replaced: use_repl
    };
  end

endmodule

// ===== sv/srfm_cell.sv =====
// One cell of the output row: holds a single beat and its valid bit.
// Loads in parallel or takes its right neighbor's beat. Depends on srfm_pkg.
`timescale 1ns / 1ps

module srfm_cell (
  input  logic                clk,
  input  logic                rst,
  input  srfm_pkg::cell_ctl_t ctl,
  input  srfm_pkg::beat_t     load_beat,
  input  logic                load_valid,
  input  srfm_pkg::beat_t     next_beat,
  input  logic                next_valid,
  output srfm_pkg::beat_t     beat,
  output logic                valid
);
  import srfm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= load_valid;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      beat <= load_beat;
    end else if (ctl.shift) begin
      beat <= next_beat;
    end
  end

endmodule

// ===== sv/srfm_queue.sv =====
// Output row: a chain of srfm_cell instances, head cell drives the output.
// Whole row loads at once; beats shift one cell toward the head per pop.
// Depends on srfm_pkg and srfm_cell.
`timescale 1ns / 1ps

module srfm_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  srfm_pkg::beat_t [srfm_pkg::QDEPTH-1:0] load_beats,
  input  srfm_pkg::qcnt_t                        load_count,
  input  logic                                   out_stall,
  output srfm_pkg::beat_t                        head,
  output logic                                   head_valid,
  output logic                                   ready
);
  import srfm_pkg::*;

  beat_t [QDEPTH-1:0] beat;
  logic  [QDEPTH-1:0] valid;
  logic               pop;
  cell_ctl_t          ctl;

  assign pop        = valid[0] && !out_stall;
  // valid bits are always contiguous from the head
  assign ready      = !valid[1] && (!valid[0] || pop);
  assign ctl.load   = load;
  assign ctl.shift  = pop;
  assign head       = beat[0];
  assign head_valid = valid[0];

  for (genvar k = 0; k < QDEPTH; k++) begin : g_cell
    beat_t nbeat;
    logic  nvalid;
    if (k + 1 < QDEPTH) begin : g_mid
      assign nbeat  = beat[k + 1];
      assign nvalid = valid[k + 1];
    end else begin : g_end
      assign nbeat  = beat[k];
      assign nvalid = 1'b0;
    end
    srfm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .load_beat  (load_beats[k]),
      .load_valid (qcnt_t'(k) < load_count),
      .next_beat  (nbeat),
      .next_valid (nvalid),
      .beat       (beat[k]),
      .valid      (valid[k])
    );
  end

endmodule

// ===== sv/stream_replace_first_match_top.sv =====
// Top level of stream_replace_first_match: match engine feeding the output row.
// Depends on srfm_pkg, srfm_match, srfm_queue.
//
//  channel  dir  handshake             payload
//  in       in   in_valid / in_stall   in_byte, in_last
//  out      out  out_valid / out_stall out_byte, out_last, out_replaced
//  cfg      in   cfg_write             cfg_index, cfg_data
//
// An accepted item's beats are loaded into the output row, the first into the head cell,
// and are shown in the cycle after the accept. The output row drains one beat per cycle
// through its head cell while out_stall is low; one byte in, one beat out runs every cycle unstalled.
// Input is taken when the row is empty or its one remaining beat leaves that cycle.
// out_stall freezes the head beat; rst (synchronous) clears row, match state, registers.
`timescale 1ns / 1ps

module stream_replace_first_match_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [srfm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [srfm_pkg::TEXT_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  srfm_pkg::byte_t                 in_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output srfm_pkg::byte_t                 out_byte,
  output logic                            out_last,
  output logic                            out_replaced
);
  import srfm_pkg::*;

  cfg_wr_t            cfg;
  logic               accept;
  logic               q_ready;
  beat_t [QDEPTH-1:0] emit;
  qcnt_t              emit_count;
  beat_t              head;

  assign cfg      = '{write: cfg_write, index: cfg_index, data: cfg_data};
  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;

  srfm_match u_match (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .emit       (emit),
    .emit_count (emit_count)
  );

  srfm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_beats (emit),
    .load_count (emit_count),
    .out_stall  (out_stall),
    .head       (head),
    .head_valid (out_valid),
    .ready      (q_ready)
  );

  assign out_byte     = head.data;
  assign out_last     = head.last;
  assign out_replaced = head.replaced;

endmodule

// ===== sv/srfm_checker.sv =====
// Port-level checks for stream_replace_first_match_top, bound to the top.
// Depends on srfm_pkg and stream_replace_first_match_top_assert.svh.
`timescale 1ns / 1ps
`include "stream_replace_first_match_top_assert.svh"

module srfm_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input srfm_pkg::byte_t out_byte,
  input logic            out_last,
  input logic            out_replaced
);
  import srfm_pkg::*;

  // stalled beat stays put
  `SRFM_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_replaced), "out beat changed while stalled")

  // with nothing queued the block must take input
  `SRFM_ASSERT(a_empty_ready, clk, rst, !out_valid |-> !in_stall, "input stalled with empty output row")

  `SRFM_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid && !in_stall, "output row not cleared by reset")

endmodule

bind stream_replace_first_match_top srfm_checker u_srfm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_last     (out_last),
  .out_replaced (out_replaced)
);

// ===== verif/tb_top.sv =====
// Self-checking bench for stream_replace_first_match_top: directed and random lines.
// Depends on srfm_pkg and the block's RTL; its own line rewriter predicts every beat.
`timescale 1ns / 1ps

module tb_top;
  import srfm_pkg::*;

  localparam int          DRAIN_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 300;
  localparam longint      TIMEOUT_NS   = 3_000_000;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index    = '0;
  logic [TEXT_W-1:0]    cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  byte_t                in_byte      = '0;
  logic                 in_last      = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  byte_t                out_byte;
  logic                 out_last;
  logic                 out_replaced;

  // Rewriter state, mirrors the block's registers and line state
  logic [TEXT_W-1:0] pat_reg       = '0;
  logic [LEN_W-1:0]  pat_len       = '0;
  logic [TEXT_W-1:0] rep_reg       = '0;
  logic [LEN_W-1:0]  rep_len       = '0;
  int unsigned       prefix_cnt    = 0;
  byte_t             held [PATTERN_MAX];
  bit                line_replaced = 1'b0;

  beat_t       step_beats[$];
  beat_t       rewritten_beats[$];
  byte_t       line_buf[$];
  byte_t       alph[3];
  int unsigned fail_count  = 0;
  bit          idle_on     = 1'b1;
  int unsigned hold_reqs   = 0;
  int unsigned hold_grants = 0;
  int unsigned hold_left   = 0;

  stream_replace_first_match_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_replaced (out_replaced)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp8(logic [LEN_W-1:0] v);
    return (v > 8) ? 8 : int'(v);
  endfunction

  function automatic void emit(byte_t d, bit r);
    beat_t bt;
    bt.data     = d;
    bt.last     = 1'b0;
    bt.replaced = r;
    step_beats.push_back(bt);
  endfunction

  function automatic void emit_replacement(int unsigned rlen);
    for (int i = 0; i < rlen; i++) emit(rep_reg[8*i +: 8], 1'b1);
  endfunction

  // Beats caused by one input byte, appended to rewritten_beats
  function automatic void rewrite_byte(byte_t b, bit last);
    int unsigned plen, rlen, cnt, start, len;
    byte_t       win[PATTERN_MAX+1];
    bit          eq, kept;
    plen = clamp8(pat_len);
    rlen = clamp8(rep_len);
    step_beats.delete();
    if (prefix_cnt >= plen) prefix_cnt = 0;
    if (line_replaced) begin
      emit(b, 1'b0);
    end else if (plen == 0) begin
      emit_replacement(rlen);
      emit(b, 1'b0);
      line_replaced = 1'b1;
    end else begin
      cnt   = 0;
      start = 0;
      kept  = 1'b0;
      for (int i = 0; i < prefix_cnt; i++) begin
        win[cnt] = held[i];
        cnt++;
      end
      win[cnt] = b;
      cnt++;
      // drop held bytes from the front until the rest is a pattern prefix again
      while (start < cnt) begin
        len = cnt - start;
        eq  = 1'b1;
        for (int i = 0; i < len; i++)
          if (win[start+i] != pat_reg[8*i +: 8]) eq = 1'b0;
        if (eq) begin
          if (len >= plen) begin
            emit_replacement(rlen);
            line_replaced = 1'b1;
            prefix_cnt    = 0;
          end else begin
            for (int i = 0; i < len; i++) held[i] = win[start+i];
            prefix_cnt = len;
            kept       = 1'b1;
          end
          break;
        end
        emit(win[start], 1'b0);
        start++;
      end
      if (!kept) prefix_cnt = 0;
    end
    if (last) begin
      for (int i = 0; i < prefix_cnt; i++) emit(held[i], 1'b0);
      prefix_cnt    = 0;
      line_replaced = 1'b0;
      if (step_beats.size() > 0) step_beats[$].last = 1'b1;
    end
    foreach (step_beats[i]) rewritten_beats.push_back(step_beats[i]);
  endfunction

  // Check first: a beat never leaves in the cycle its byte is taken
  always @(posedge clk) begin : check_and_predict
    beat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (rewritten_beats.size() == 0) begin
          $error("unexpected beat: out_byte %0h out_last %0b out_replaced %0b",
                 out_byte, out_last, out_replaced);
          fail_count++;
        end else begin
          want = rewritten_beats.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
          if (out_replaced !== want.replaced) begin
            $error("out_replaced: expected %0b, got %0b", want.replaced, out_replaced);
            fail_count++;
          end
        end
      end
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_SEARCH_PATTERN: begin
            pat_reg    = cfg_data;
            prefix_cnt = 0;
          end
          REG_SEARCH_LENGTH: begin
            pat_len    = cfg_data[LEN_W-1:0];
            prefix_cnt = 0;
          end
          REG_REPLACEMENT_TEXT:   rep_reg = cfg_data;
          REG_REPLACEMENT_LENGTH: rep_len = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) rewrite_byte(in_byte, in_last);
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_grants) begin
      out_stall   <= 1'b1;
      hold_grants <= hold_grants + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 11);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [TEXT_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Leaves valid high after the beat is taken; the next call or a drain replaces it
  task automatic send_byte(byte_t b, bit last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rewritten_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly alphabet filler with the pattern (or a broken prefix of it) dropped in
  function automatic void make_line();
    int unsigned n, pos, plen, kind, k;
    plen = clamp8(pat_len);
    kind = $urandom_range(0, 9);
    n    = $urandom_range(1, 12);
    line_buf.delete();
    for (int i = 0; i < n; i++)
      line_buf.push_back((kind < 8) ? alph[$urandom_range(0, 2)] : byte_t'($urandom));
    if (kind < 6 && plen > 0) begin
      pos = $urandom_range(0, n);
      k   = (kind == 5) ? $urandom_range(1, plen) : plen;
      for (int j = 0; j < k; j++) line_buf.insert(pos + j, pat_reg[8*j +: 8]);
    end
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 4))
      0:       return 4'd0;
      1:       return 4'd8;
      2:       return 4'd15;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic randomize_config();
    logic [TEXT_W-1:0] pat;
    logic [TEXT_W-1:0] junk;
    wait_drained();
    foreach (alph[i]) alph[i] = byte_t'($urandom);
    for (int j = 0; j < 8; j++)
      pat[8*j +: 8] = ($urandom_range(0, 4) == 0) ? byte_t'($urandom)
                                                  : alph[$urandom_range(0, 2)];
    // upper bits of the length writes are don't-care
    junk = {$urandom, $urandom};
    write_reg(REG_SEARCH_PATTERN, pat);
    write_reg(REG_SEARCH_LENGTH, {junk[TEXT_W-1:LEN_W], pick_len()});
    write_reg(REG_REPLACEMENT_TEXT, {$urandom, $urandom});
    junk = {$urandom, $urandom};
    write_reg(REG_REPLACEMENT_LENGTH, {junk[TEXT_W-1:LEN_W], pick_len()});
  endtask

  task automatic run_lines(int unsigned items);
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      make_line();
      send_line();
      sent += line_buf.size();
    end
  endtask

  // Reset config: empty pattern, empty replacement; then a full replacement up front
  task automatic test_empty_pattern();
    send_byte(8'h00, 1'b1);
    wait_drained();
    write_reg(REG_SEARCH_PATTERN, 64'h0);
    write_reg(REG_REPLACEMENT_TEXT, '1);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // "aab": overlapping prefix, held bytes at line end, match on the final byte
  // with an empty replacement (no beat, no last mark)
  task automatic test_overlapping_prefixes();
    wait_drained();
    write_reg(REG_SEARCH_PATTERN, 64'h62_61_61);
    write_reg(REG_SEARCH_LENGTH, 64'd3);
    write_reg(REG_REPLACEMENT_TEXT, 64'h59_58);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
    send_byte("a", 1'b0);
    send_byte("a", 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    send_byte("a", 1'b0);
    send_byte("a", 1'b1);
    wait_drained();
    write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
    send_byte("x", 1'b0);
    send_byte("a", 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
  endtask

  // Held prefix is dropped when the search length changes mid-line
  task automatic test_pattern_change_mid_line();
    wait_drained();
    write_reg(REG_REPLACEMENT_LENGTH, 64'd3);
    send_byte("a", 1'b0);
    send_byte("a", 1'b0);
    wait_drained();
    write_reg(REG_SEARCH_LENGTH, 64'hF);
    send_byte("b", 1'b1);
  endtask

  // Lengths above eight count as eight
  task automatic test_length_clamp();
    wait_drained();
    write_reg(REG_SEARCH_PATTERN, '1);
    write_reg(REG_SEARCH_LENGTH, 64'd9);
    write_reg(REG_REPLACEMENT_TEXT, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7);
  endtask

  task automatic test_random_lines(int unsigned phases);
    for (int p = 0; p < phases; p++) begin
      randomize_config();
      idle_on = (p != 1);
      run_lines(36);
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_output_backpressure();
    randomize_config();
    hold_reqs++;
    run_lines(40);
  endtask

  task automatic test_sender_pause();
    randomize_config();
    run_lines(20);
    wait_drained();
    run_lines(20);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_pattern();
    test_overlapping_prefixes();
    test_pattern_change_mid_line();
    test_length_clamp();
    test_random_lines(5);
    test_output_backpressure();
    test_sender_pause();
    wait_drained();
    if (fail_count == 0)
      $display("stream_replace_first_match_top: match");
    else
      $display("stream_replace_first_match_top: mismatch");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("stream_replace_first_match_top: mismatch");
    $finish;
  end

endmodule
